>>> rtl/tsu_pkg.sv
`default_nettype none

package tsu_pkg;

    // Store geometry
    localparam int STORE_DEPTH  = 32;
    localparam int SET_CAPACITY = 32;   // 1 .. STORE_DEPTH
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int VALUE_W      = 32;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(SET_CAPACITY);

    // Command queue between front and back (power of two depth)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Input command codes
    localparam logic [2:0] CMD_CLEAR = 3'd0;
    localparam logic [2:0] CMD_ADD   = 3'd1;
    localparam logic [2:0] CMD_QUERY = 3'd2;
    localparam logic [2:0] CMD_UNION = 3'd3;
    localparam logic [2:0] CMD_INTER = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_ELEM  = 2'd2;
    localparam logic [1:0] KIND_EMPTY = 2'd3;

    // Status codes
    localparam logic [1:0] ST_ADDED   = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_ABSENT  = 2'd0;
    localparam logic [1:0] ST_FOUND   = 2'd1;
    localparam logic [1:0] ST_NONE    = 2'd0;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_ADD,
        OP_QUERY,
        OP_UNION,
        OP_INTER
    } op_t;

    typedef struct packed {
        op_t                op;
        logic               sel;
        logic [VALUE_W-1:0] value;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         status;
        logic [VALUE_W-1:0] element;
        logic               last;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/tsu_front.sv
`default_nettype none

module tsu_front
    import tsu_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_vld,
    output logic                    in_rdy,
    input  wire logic [2:0]         command,
    input  wire logic               set_select,
    input  wire logic [VALUE_W-1:0] value,
    output logic                    push_vld,
    output cmd_item_t               push_item,
    input  wire logic               push_rdy
);

    logic      vld_reg;
    cmd_item_t item_reg;
    cmd_item_t item_next;
    logic      known;

    // Map command code to operation; unknown codes are dropped here
    always_comb
    begin
        item_next.sel   = set_select;
        item_next.value = value;
        known           = 1'b1;
        case (command)
            CMD_CLEAR: item_next.op = OP_CLEAR;
            CMD_ADD:   item_next.op = OP_ADD;
            CMD_QUERY: item_next.op = OP_QUERY;
            CMD_UNION: item_next.op = OP_UNION;
            CMD_INTER: item_next.op = OP_INTER;
            default:
            begin
                item_next.op = OP_CLEAR;
                known        = 1'b0;
            end
        endcase
    end

    assign in_rdy    = !vld_reg || push_rdy;
    assign push_vld  = vld_reg;
    assign push_item = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= 1'b0;
            item_reg <= '0;
        end
        else if (in_vld && in_rdy)
        begin
            vld_reg  <= known;
            item_reg <= item_next;
        end
        else if (push_rdy)
        begin
            vld_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tsu_queue.sv
`default_nettype none

module tsu_queue
    import tsu_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push_vld,
    input  wire cmd_item_t push_item,
    output logic           push_rdy,
    output logic           pop_vld,
    output cmd_item_t      pop_item,
    input  wire logic      pop_rdy
);

    cmd_item_t         q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              push;
    logic              pop;

    assign push_rdy = count_reg != (QPTR_W+1)'(QUEUE_DEPTH);
    assign pop_vld  = count_reg != '0;
    assign pop_item = q_mem[rd_ptr_reg];
    assign push     = push_vld && push_rdy;
    assign pop      = pop_vld && pop_rdy;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/tsu_back.sv
`default_nettype none

module tsu_back
    import tsu_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      pop_vld,
    input  wire cmd_item_t pop_item,
    output logic           pop_rdy,
    output logic           res_vld,
    output result_t        res,
    input  wire logic      res_rdy
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_IN_RD,
        S_IN_CMP,
        S_OUT_RD,
        S_OUT_CMP,
        S_RESOLVE,
        S_TAKE,
        S_NEXT,
        S_PHASE_B,
        S_FINAL
    } state_t;

    logic [VALUE_W-1:0] mem_a [STORE_DEPTH];
    logic [VALUE_W-1:0] mem_b [STORE_DEPTH];
    logic [VALUE_W-1:0] rdata_a_reg;
    logic [VALUE_W-1:0] rdata_b_reg;

    state_t             state_reg;
    op_t                op_reg;
    logic               sel_reg;
    logic [VALUE_W-1:0] key_reg;
    logic [CNT_W-1:0]   cnt_a_reg;
    logic [CNT_W-1:0]   cnt_b_reg;
    logic [ADDR_W-1:0]  oidx_reg;
    logic [ADDR_W-1:0]  kidx_reg;
    logic [CNT_W-1:0]   n_reg;
    logic               outer_b_reg;
    logic               inner_b_reg;
    logic               phase_b_reg;
    logic               found_reg;
    logic               hold_vld_reg;
    logic [VALUE_W-1:0] hold_reg;
    logic               out_vld_reg;
    result_t            out_reg;

    logic [ADDR_W-1:0]  rd_addr;
    logic [VALUE_W-1:0] rdata_in;
    logic [VALUE_W-1:0] rdata_out;
    logic [CNT_W-1:0]   inner_cnt;
    logic [CNT_W-1:0]   outer_cnt;
    logic [CNT_W-1:0]   sel_cnt;
    logic [CNT_W-1:0]   pop_cnt;
    logic               out_free;
    logic               out_load;
    logic               add_ok;
    logic               last_in;
    logic               last_out;
    logic               qualify;
    logic               wr_en;

    assign rd_addr   = (state_reg == S_IN_RD) ? kidx_reg : oidx_reg;
    assign rdata_in  = inner_b_reg ? rdata_b_reg : rdata_a_reg;
    assign rdata_out = outer_b_reg ? rdata_b_reg : rdata_a_reg;
    assign inner_cnt = inner_b_reg ? cnt_b_reg : cnt_a_reg;
    assign outer_cnt = outer_b_reg ? cnt_b_reg : cnt_a_reg;
    assign sel_cnt   = sel_reg ? cnt_b_reg : cnt_a_reg;
    assign pop_cnt   = pop_item.sel ? cnt_b_reg : cnt_a_reg;
    assign out_free  = !out_vld_reg || res_rdy;
    assign add_ok    = !found_reg && (sel_cnt < CAP_CNT);
    assign last_in   = ({1'b0, kidx_reg} + 1'b1) == inner_cnt;
    assign last_out  = ({1'b0, oidx_reg} + 1'b1) == outer_cnt;
    // union keeps B members missing from A, intersection keeps A members found in B
    assign qualify   = (op_reg == OP_UNION) ? !found_reg : found_reg;
    assign wr_en     = (state_reg == S_RESOLVE) && (op_reg == OP_ADD) && out_free && add_ok;
    // output register is reloaded this cycle
    assign out_load  = out_free &&
                       ((state_reg == S_RESOLVE && (op_reg == OP_ADD || op_reg == OP_QUERY)) ||
                        (state_reg == S_TAKE && hold_vld_reg) ||
                        (state_reg == S_FINAL));

    assign pop_rdy = state_reg == S_IDLE;
    assign res_vld = out_vld_reg;
    assign res     = out_reg;

    // One read port per store, registered; one write port for add
    always_ff @(posedge clk)
    begin
        rdata_a_reg <= mem_a[rd_addr];
        rdata_b_reg <= mem_b[rd_addr];
        if (wr_en && !sel_reg)
        begin
            mem_a[sel_cnt[ADDR_W-1:0]] <= key_reg;
        end
        if (wr_en && sel_reg)
        begin
            mem_b[sel_cnt[ADDR_W-1:0]] <= key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= OP_CLEAR;
            sel_reg      <= 1'b0;
            key_reg      <= '0;
            cnt_a_reg    <= '0;
            cnt_b_reg    <= '0;
            oidx_reg     <= '0;
            kidx_reg     <= '0;
            n_reg        <= '0;
            outer_b_reg  <= 1'b0;
            inner_b_reg  <= 1'b0;
            phase_b_reg  <= 1'b0;
            found_reg    <= 1'b0;
            hold_vld_reg <= 1'b0;
            hold_reg     <= '0;
            out_vld_reg  <= 1'b0;
            out_reg      <= '0;
        end
        else
        begin
            if (out_vld_reg && res_rdy && !out_load)
            begin
                out_vld_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (pop_vld)
                    begin
                        op_reg       <= pop_item.op;
                        sel_reg      <= pop_item.sel;
                        key_reg      <= pop_item.value;
                        oidx_reg     <= '0;
                        kidx_reg     <= '0;
                        n_reg        <= '0;
                        phase_b_reg  <= 1'b0;
                        found_reg    <= 1'b0;
                        hold_vld_reg <= 1'b0;
                        case (pop_item.op)
                            OP_CLEAR:
                            begin
                                if (pop_item.sel)
                                begin
                                    cnt_b_reg <= '0;
                                end
                                else
                                begin
                                    cnt_a_reg <= '0;
                                end
                            end
                            OP_ADD, OP_QUERY:
                            begin
                                inner_b_reg <= pop_item.sel;
                                state_reg   <= (pop_cnt == '0) ? S_RESOLVE : S_IN_RD;
                            end
                            OP_UNION:
                            begin
                                outer_b_reg <= 1'b0;
                                inner_b_reg <= 1'b0;
                                state_reg   <= (cnt_a_reg == '0) ? S_PHASE_B : S_OUT_RD;
                            end
                            OP_INTER:
                            begin
                                outer_b_reg <= 1'b0;
                                inner_b_reg <= 1'b1;
                                state_reg   <= (cnt_a_reg == '0) ? S_FINAL : S_OUT_RD;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_IN_RD:
                begin
                    state_reg <= S_IN_CMP;
                end
                S_IN_CMP:
                begin
                    if (rdata_in == key_reg)
                    begin
                        found_reg <= 1'b1;
                        state_reg <= S_RESOLVE;
                    end
                    else if (last_in)
                    begin
                        found_reg <= 1'b0;
                        state_reg <= S_RESOLVE;
                    end
                    else
                    begin
                        kidx_reg  <= kidx_reg + 1'b1;
                        state_reg <= S_IN_RD;
                    end
                end
                S_OUT_RD:
                begin
                    state_reg <= S_OUT_CMP;
                end
                S_OUT_CMP:
                begin
                    key_reg   <= rdata_out;
                    kidx_reg  <= '0;
                    found_reg <= 1'b0;
                    if (op_reg == OP_UNION && !phase_b_reg)
                    begin
                        state_reg <= S_TAKE;
                    end
                    else if (inner_cnt == '0)
                    begin
                        state_reg <= S_RESOLVE;
                    end
                    else
                    begin
                        state_reg <= S_IN_RD;
                    end
                end
                S_RESOLVE:
                begin
                    if (op_reg == OP_ADD || op_reg == OP_QUERY)
                    begin
                        if (out_free)
                        begin
                            out_vld_reg     <= 1'b1;
                            out_reg.element <= '0;
                            out_reg.last    <= 1'b1;
                            if (op_reg == OP_ADD)
                            begin
                                out_reg.kind <= KIND_ADD;
                                if (found_reg)
                                begin
                                    out_reg.status <= ST_PRESENT;
                                end
                                else if (add_ok)
                                begin
                                    out_reg.status <= ST_ADDED;
                                    if (sel_reg)
                                    begin
                                        cnt_b_reg <= cnt_b_reg + 1'b1;
                                    end
                                    else
                                    begin
                                        cnt_a_reg <= cnt_a_reg + 1'b1;
                                    end
                                end
                                else
                                begin
                                    out_reg.status <= ST_FULL;
                                end
                            end
                            else
                            begin
                                out_reg.kind   <= KIND_QUERY;
                                out_reg.status <= found_reg ? ST_FOUND : ST_ABSENT;
                            end
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        state_reg <= qualify ? S_TAKE : S_NEXT;
                    end
                end
                S_TAKE:
                begin
                    // one element is held back so the final one can carry last
                    if (!hold_vld_reg)
                    begin
                        hold_reg     <= key_reg;
                        hold_vld_reg <= 1'b1;
                        n_reg        <= n_reg + 1'b1;
                        state_reg    <= S_NEXT;
                    end
                    else if (out_free)
                    begin
                        out_vld_reg <= 1'b1;
                        out_reg     <= '{KIND_ELEM, ST_NONE, hold_reg, 1'b0};
                        hold_reg    <= key_reg;
                        n_reg       <= n_reg + 1'b1;
                        state_reg   <= S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    if (last_out)
                    begin
                        state_reg <= (op_reg == OP_UNION && !phase_b_reg) ? S_PHASE_B : S_FINAL;
                    end
                    else if (n_reg == CAP_CNT)
                    begin
                        state_reg <= S_FINAL;
                    end
                    else
                    begin
                        oidx_reg  <= oidx_reg + 1'b1;
                        state_reg <= S_OUT_RD;
                    end
                end
                S_PHASE_B:
                begin
                    phase_b_reg <= 1'b1;
                    outer_b_reg <= 1'b1;
                    inner_b_reg <= 1'b0;
                    oidx_reg    <= '0;
                    state_reg   <= (cnt_b_reg == '0 || n_reg == CAP_CNT) ? S_FINAL : S_OUT_RD;
                end
                S_FINAL:
                begin
                    if (out_free)
                    begin
                        out_vld_reg <= 1'b1;
                        if (hold_vld_reg)
                        begin
                            out_reg <= '{KIND_ELEM, ST_NONE, hold_reg, 1'b1};
                        end
                        else
                        begin
                            out_reg <= '{KIND_EMPTY, ST_NONE, {VALUE_W{1'b0}}, 1'b1};
                        end
                        hold_vld_reg <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/two_set_store_union_intersection_unit.sv
// Two-set store: keeps sets A and B of signed 32-bit values (up to 32 each,
// insertion order) and runs clear / add / query / union / intersection.
// Input stream (s_*): one transaction per command. s_tuser holds command and
// set_select, s_tdata the value. Codes 5..7 are dropped with no result.
// Output stream (m_*): result transactions. Add and query give one result;
// union and intersection give one result per element, m_tlast on the final
// one, or a single empty-set result. Clear gives nothing.
// A command passes the front register and the queue, then the back
// sequencer runs it: add/query scan the selected set, union walks A and then
// checks each B entry against A, intersection checks each A entry against B.
// Each store has one registered read port, so every membership check walks
// the other set one entry at a time, a read state then a compare state per
// entry. The back takes the next command only once it is idle again.
// The front accepts and decodes commands into a 2-deep queue, so a few
// commands can be taken while the back is busy or the output is stalled.
// When m_tready is low the back holds the pending result and waits.
// Reset (rst_n, async, active low) empties both sets and the queue; store
// contents are not cleared, only the counts.
`default_nettype none

module two_set_store_union_intersection_unit
    import tsu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic [3:0]  s_tuser,   // [2:0] command, [3] set_select
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [1:0] status, [33:2] element, [39:34] zero
    output logic [1:0]       m_tuser,   // [1:0] result_kind
    output logic             m_tlast    // last result of the transaction's command
);

    logic      push_vld;
    logic      push_rdy;
    cmd_item_t push_item;
    logic      pop_vld;
    logic      pop_rdy;
    cmd_item_t pop_item;
    logic      res_vld;
    result_t   res;

    tsu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_vld     (s_tvalid),
        .in_rdy     (s_tready),
        .command    (s_tuser[2:0]),
        .set_select (s_tuser[3]),
        .value      (s_tdata),
        .push_vld   (push_vld),
        .push_item  (push_item),
        .push_rdy   (push_rdy)
    );

    tsu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_vld  (push_vld),
        .push_item (push_item),
        .push_rdy  (push_rdy),
        .pop_vld   (pop_vld),
        .pop_item  (pop_item),
        .pop_rdy   (pop_rdy)
    );

    tsu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop_vld  (pop_vld),
        .pop_item (pop_item),
        .pop_rdy  (pop_rdy),
        .res_vld  (res_vld),
        .res      (res),
        .res_rdy  (m_tready)
    );

    assign m_tvalid = res_vld;
    assign m_tdata  = {6'b0, res.element, res.status};
    assign m_tuser  = res.kind;
    assign m_tlast  = res.last;

`ifndef ASSERT_OFF
    // front must stall the input while its slot cannot drain into a full queue
    a_front_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (push_vld && !push_rdy) |-> !s_tready)
        else $error("input accepted while front slot blocked");

    // single-result answers always close their command
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_ADD || m_tuser == KIND_QUERY ||
                      m_tuser == KIND_EMPTY)) |-> m_tlast)
        else $error("single result without last");

    // element results carry no status
    a_elem_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_ELEM) |-> (m_tdata[1:0] == ST_NONE))
        else $error("element result with nonzero status");

    // the back takes a command only when idle; any but clear moves it out of idle
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_vld && pop_rdy) |=> !(pop_rdy && $past(pop_item.op) != OP_CLEAR))
        else $error("back took a command while busy");
`endif

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tsu_pkg::*;

    // Codes 5..7 are reserved: the block drops them without a result.
    localparam logic [2:0] CMD_RSVD_LO = 3'd5;
    localparam logic [2:0] CMD_RSVD_HI = 3'd7;

    localparam logic SEL_A = 1'b0;
    localparam logic SEL_B = 1'b1;

    // Worst case is a full intersection of two disjoint sets plus output stalls.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 2500;
    localparam int MAX_REPORTS    = 10;
    localparam int MIX_ITEMS      = 50;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [31:0]        s_tdata;     // [31:0] value
    logic [3:0]         s_tuser;     // [2:0] command, [3] set_select
    logic               m_tvalid;
    logic               m_tready;
    logic [39:0]        m_tdata;     // [1:0] status, [33:2] element, [39:34] zero
    logic [1:0]         m_tuser;     // [1:0] result_kind
    logic               m_tlast;

    // Shadow copy of both sets, in insertion order
    logic [VALUE_W-1:0] set_a[$];
    logic [VALUE_W-1:0] set_b[$];
    // Scratch list for building union / intersection output
    logic [VALUE_W-1:0] emit_list[$];
    // Results still owed by the block, oldest first
    result_t            pending_results[$];

    int                 mismatch_count;
    int                 stuck_cycles;
    bit                 idle_on;
    bit                 stall_on;

    two_set_store_union_intersection_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Set model
    // ------------------------------------------------------------------

    function automatic bit set_holds(input logic in_b, input logic [VALUE_W-1:0] v);
        bit hit;
        hit = 1'b0;
        if (in_b)
        begin
            for (int i = 0; i < set_b.size(); i++)
                if (set_b[i] == v)
                    hit = 1'b1;
        end
        else
        begin
            for (int i = 0; i < set_a.size(); i++)
                if (set_a[i] == v)
                    hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic bit listed(input logic [VALUE_W-1:0] v);
        bit hit;
        hit = 1'b0;
        for (int i = 0; i < emit_list.size(); i++)
            if (emit_list[i] == v)
                hit = 1'b1;
        return hit;
    endfunction

    function automatic void owe_result(input logic [1:0] kind, input logic [1:0] status,
                                       input logic [VALUE_W-1:0] element, input logic last);
        result_t r;
        r.kind    = kind;
        r.status  = status;
        r.element = element;
        r.last    = last;
        pending_results.push_back(r);
    endfunction

    // Union / intersection output: one element per result, or one empty marker
    function automatic void owe_list();
        if (emit_list.size() == 0)
            owe_result(KIND_EMPTY, ST_NONE, '0, 1'b1);
        else
            for (int i = 0; i < emit_list.size(); i++)
                owe_result(KIND_ELEM, ST_NONE, emit_list[i], i == emit_list.size() - 1);
    endfunction

    // Applies one accepted command to the shadow sets and queues its results
    function automatic void apply_command(input logic [2:0] cmd, input logic sel,
                                          input logic [VALUE_W-1:0] v);
        logic [1:0] st;
        case (cmd)
            CMD_CLEAR:
            begin
                if (sel)
                    set_b.delete();
                else
                    set_a.delete();
            end
            CMD_ADD:
            begin
                // presence beats full
                if (set_holds(sel, v))
                    st = ST_PRESENT;
                else if ((sel ? set_b.size() : set_a.size()) >= SET_CAPACITY)
                    st = ST_FULL;
                else
                begin
                    st = ST_ADDED;
                    if (sel)
                        set_b.push_back(v);
                    else
                        set_a.push_back(v);
                end
                owe_result(KIND_ADD, st, '0, 1'b1);
            end
            CMD_QUERY:
                owe_result(KIND_QUERY, set_holds(sel, v) ? ST_FOUND : ST_ABSENT, '0, 1'b1);
            CMD_UNION:
            begin
                emit_list.delete();
                for (int i = 0; i < set_a.size(); i++)
                    if (!listed(set_a[i]) && emit_list.size() < SET_CAPACITY)
                        emit_list.push_back(set_a[i]);
                for (int i = 0; i < set_b.size(); i++)
                    if (!listed(set_b[i]) && emit_list.size() < SET_CAPACITY)
                        emit_list.push_back(set_b[i]);
                owe_list();
            end
            CMD_INTER:
            begin
                emit_list.delete();
                for (int i = 0; i < set_a.size(); i++)
                    if (set_holds(SEL_B, set_a[i]) && !listed(set_a[i])
                        && emit_list.size() < SET_CAPACITY)
                        emit_list.push_back(set_a[i]);
                owe_list();
            end
            default:
            begin
                // reserved code: no state change, no result
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every output transaction against the oldest expectation
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: kind=%0d status=%0d element=%h last=%0d",
                             m_tuser, m_tdata[1:0], m_tdata[33:2], m_tlast);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.kind || m_tdata[1:0] !== want.status
                    || m_tdata[33:2] !== want.element || m_tlast !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"result mismatch: exp kind=%0d status=%0d element=%h",
                                  " last=%0d / got kind=%0d status=%0d element=%h last=%0d"},
                                 want.kind, want.status, want.element, want.last,
                                 m_tuser, m_tdata[1:0], m_tdata[33:2], m_tlast);
                end
            end
        end
    end

    // Watchdog: too long with no transaction on either side ends the run
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver backpressure: random stall bursts of random length while enabled
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_on && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // One command transaction. Called and returns at a falling edge; valid
    // stays high so the next call can follow back to back.
    task automatic send_cmd(input logic [2:0] cmd, input logic sel,
                            input logic [VALUE_W-1:0] v);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {sel, cmd};
        s_tdata  <= v;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_command(cmd, sel, v);
        @(negedge clk);
    endtask

    // Hold off the sender until every owed result has come out
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, each command, empty answers, duplicates, reserved codes
    task automatic test_directed();
        send_cmd(CMD_UNION, SEL_A, '0);              // both sets empty
        send_cmd(CMD_INTER, SEL_B, '0);
        send_cmd(CMD_ADD,   SEL_A, 32'h8000_0000);
        send_cmd(CMD_ADD,   SEL_A, 32'h7FFF_FFFF);
        send_cmd(CMD_ADD,   SEL_A, 32'h0000_0000);
        send_cmd(CMD_ADD,   SEL_A, 32'h8000_0000);   // already present
        send_cmd(CMD_QUERY, SEL_A, 32'h7FFF_FFFF);
        send_cmd(CMD_QUERY, SEL_B, 32'h7FFF_FFFF);
        send_cmd(CMD_INTER, SEL_A, '0);              // B empty -> empty answer
        send_cmd(CMD_ADD,   SEL_B, 32'hFFFF_FFFF);
        send_cmd(CMD_ADD,   SEL_B, 32'h7FFF_FFFF);
        send_cmd(CMD_UNION, SEL_A, '0);
        send_cmd(CMD_INTER, SEL_B, 32'hFFFF_FFFF);   // select and value ignored
        send_cmd(CMD_RSVD_LO,          SEL_A, 32'h7FFF_FFFF);
        send_cmd(CMD_RSVD_LO + 3'd1,   SEL_B, 32'hFFFF_FFFF);
        send_cmd(CMD_RSVD_HI,          SEL_B, 32'h8000_0000);
        send_cmd(CMD_CLEAR, SEL_A, 32'hFFFF_FFFF);
        send_cmd(CMD_QUERY, SEL_A, 32'h0000_0000);   // gone after clear
        send_cmd(CMD_UNION, SEL_B, '0);
        send_cmd(CMD_QUERY, SEL_B, 32'hFFFF_FFFF);
        wait_results_drained();
    endtask

    // Union cut at capacity, then full set: full refusal, present-on-full
    task automatic test_capacity();
        logic [VALUE_W-1:0] fresh;
        send_cmd(CMD_CLEAR, SEL_A, $urandom);
        send_cmd(CMD_CLEAR, SEL_B, $urandom);
        for (int i = 0; i < SET_CAPACITY - 4; i++)
            send_cmd(CMD_ADD, SEL_A, $urandom);
        // B shares every fourth member with A; the rest run the union past capacity
        for (int i = 0; i < 8; i++)
            send_cmd(CMD_ADD, SEL_B, (i % 4 == 0) ? set_a[i] : $urandom);
        send_cmd(CMD_UNION, SEL_A, '0);
        send_cmd(CMD_INTER, SEL_A, '0);
        for (int i = 0; i < 4; i++)
            send_cmd(CMD_ADD, SEL_A, $urandom);
        fresh = $urandom;
        send_cmd(CMD_ADD,   SEL_A, fresh);           // full
        send_cmd(CMD_ADD,   SEL_A, set_a[3]);        // present wins over full
        send_cmd(CMD_QUERY, SEL_A, set_a[set_a.size() - 1]);
        send_cmd(CMD_QUERY, SEL_A, fresh);
        send_cmd(CMD_UNION, SEL_B, '0);
        send_cmd(CMD_INTER, SEL_B, '0);
        wait_results_drained();
    endtask

    // Random mix over a small value pool so hits and duplicates are common
    task automatic test_random_mix();
        logic [VALUE_W-1:0] pool [12];
        logic [VALUE_W-1:0] v;
        logic [2:0]         cmd;
        int                 pick;
        pool[0] = 32'h8000_0000;
        pool[1] = 32'h7FFF_FFFF;
        pool[2] = 32'h0000_0000;
        pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 12; i++)
            pool[i] = $urandom;
        for (int n = 0; n < MIX_ITEMS; n++)
        begin
            // last stretch runs at full rate on both sides
            if (n == MIX_ITEMS - 30)
            begin
                idle_on  = 1'b0;
                stall_on = 1'b0;
            end
            if (n == MIX_ITEMS / 2)
                wait_results_drained();
            pick = $urandom_range(0, 99);
            if (pick < 6)
                cmd = CMD_CLEAR;
            else if (pick < 46)
                cmd = CMD_ADD;
            else if (pick < 70)
                cmd = CMD_QUERY;
            else if (pick < 82)
                cmd = CMD_UNION;
            else if (pick < 94)
                cmd = CMD_INTER;
            else
                cmd = CMD_RSVD_LO + 3'($urandom_range(0, CMD_RSVD_HI - CMD_RSVD_LO));
            v = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 11)] : $urandom;
            send_cmd(cmd, 1'($urandom_range(0, 1)), v);
        end
        wait_results_drained();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        mismatch_count = 0;
        stuck_cycles   = 0;
        idle_on        = 1'b1;
        stall_on       = 1'b1;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_capacity();
        test_random_mix();

        // A trailing clear or reserved code may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
